### rtl/lsf_pkg.sv
// Shared types, constants and CRC helpers for the log slot framer.
// Used by the front end, queue, back end and top level; depends on nothing.
package lsf_pkg;

  // Line framing characters
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // CRC-32 preset, and the sequence value that is skipped
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] SEQ_SKIP = 32'hFFFF_FFFF;

  // Depth of the request queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  // Input item and result item payloads
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [63:0] slot_word;
    logic [3:0]  word_index;
    logic        last_word;
    logic [6:0]  record_length;
  } slot_item_t;

  // One request from front to back: up to three released bytes, oldest
  // in the low byte, and a flag that closes the line after them.
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  count;
    logic        finish;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    logic     full;
    q_entry_t head;
  } q_status_t;

  // Reflected CRC-32 (poly 0xEDB88320) nibble table
  function automatic logic [31:0] crc_nib(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'h0: v = 32'h00000000;
      4'h1: v = 32'h1DB71064;
      4'h2: v = 32'h3B6E20C8;
      4'h3: v = 32'h26D930AC;
      4'h4: v = 32'h76DC4190;
      4'h5: v = 32'h6B6B51F4;
      4'h6: v = 32'h4DB26158;
      4'h7: v = 32'h5005713C;
      4'h8: v = 32'hEDB88320;
      4'h9: v = 32'hF00F9344;
      4'hA: v = 32'hD6D6A3E8;
      4'hB: v = 32'hCB61B38C;
      4'hC: v = 32'h9B64C2B0;
      4'hD: v = 32'h86D3D2D4;
      4'hE: v = 32'hA00AE278;
      4'hF: v = 32'hBDBDF21C;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Fold one byte into the CRC, low nibble first
  function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = crc_nib(c[3:0] ^ b[3:0]) ^ (c >> 4);
    return crc_nib(x[3:0] ^ b[7:4]) ^ (x >> 4);
  endfunction

endpackage

### rtl/lsf_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
// Payload type is set per instance, usually from lsf_pkg.
interface lsf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/lsf_front.sv
// Front end: accepts text bytes, holds the last two, strips CR LF or LF
// at end of line and pushes release requests. Depends on lsf_pkg.
module lsf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lsf_stream_if.sink           text_i,
  input  logic                 q_full_i,
  output lsf_pkg::q_push_t     push_o
);

  logic [15:0] held_q, held_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic        accept;
  logic [7:0]  b;
  logic [7:0]  prev;
  logic [23:0] tail;
  logic [1:0]  k;

  assign text_i.ready = !q_full_i;
  assign accept       = text_i.valid && !q_full_i;
  assign b            = text_i.payload.text_byte;

  // Classify the byte: hold, release oldest, or close the line
  always_comb begin
    held_d = held_q;
    hcnt_d = hcnt_q;
    push_o = '0;
    prev   = '0;
    tail   = '0;
    k      = '0;
    case (hcnt_q)
      2'd0: begin
        tail = {16'h0000, b};
        prev = '0;
      end
      2'd1: begin
        tail = {8'h00, b, held_q[7:0]};
        prev = held_q[7:0];
      end
      default: begin
        tail = {b, held_q[15:8], held_q[7:0]};
        prev = held_q[15:8];
      end
    endcase
    if (accept) begin
      if (!text_i.payload.end_of_text) begin
        case (hcnt_q)
          2'd0: begin
            held_d[7:0] = b;
            hcnt_d      = 2'd1;
          end
          2'd1: begin
            held_d[15:8] = b;
            hcnt_d       = 2'd2;
          end
          default: begin
            push_o.push         = 1'b1;
            push_o.entry.bytes  = {16'h0000, held_q[7:0]};
            push_o.entry.count  = 2'd1;
            push_o.entry.finish = 1'b0;
            held_d              = {b, held_q[15:8]};
          end
        endcase
      end else begin
        // Drop a trailing CR LF or a lone LF
        k = hcnt_q + 2'd1;
        if (hcnt_q != 2'd0 && prev == lsf_pkg::CHAR_CR && b == lsf_pkg::CHAR_LF) begin
          k = hcnt_q - 2'd1;
        end else if (b == lsf_pkg::CHAR_LF) begin
          k = hcnt_q;
        end
        push_o.push         = 1'b1;
        push_o.entry.bytes  = tail;
        push_o.entry.count  = k;
        push_o.entry.finish = 1'b1;
        hcnt_d              = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= 2'd0;
    end else begin
      hcnt_q <= hcnt_d;
    end
  end

  // Held bytes are payload; the count qualifies them
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

### rtl/lsf_queue.sv
// Short request queue between the front and back ends of the framer.
// Depends on lsf_pkg for the entry type and depth.
module lsf_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsf_pkg::q_push_t     push_i,
  input  logic                 pop_i,
  output lsf_pkg::q_status_t   status_o
);

  localparam int unsigned CntW = $clog2(lsf_pkg::Q_DEPTH + 1);

  lsf_pkg::q_entry_t              mem_q [lsf_pkg::Q_DEPTH];
  logic [lsf_pkg::Q_PTR_W-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign do_push = push_i.push && (cnt_q != CntW'(lsf_pkg::Q_DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  assign status_o.valid = (cnt_q != '0);
  assign status_o.full  = (cnt_q == CntW'(lsf_pkg::Q_DEPTH));
  assign status_o.head  = mem_q[rd_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == lsf_pkg::Q_PTR_W'(lsf_pkg::Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == lsf_pkg::Q_PTR_W'(lsf_pkg::Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

endmodule

### rtl/lsf_back.sv
// Back end: places slot bytes one per cycle unless stalled, runs the CRC,
// pads, appends the CRC, sends words via an output register; needs lsf_pkg.
module lsf_back #(
  parameter int unsigned SLOT_BYTES = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsf_pkg::q_status_t   q_i,
  output logic                 pop_o,
  lsf_stream_if.source         slot_o,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_data_i,
  output logic [31:0]          seq_o
);

  localparam int unsigned PosW = $clog2(SLOT_BYTES);
  localparam logic [PosW-1:0] CrcPos   = PosW'(SLOT_BYTES - 4);
  localparam logic [PosW-1:0] SlotLast = PosW'(SLOT_BYTES - 1);

  typedef enum logic {
    ST_TEXT,
    ST_FIN
  } state_e;

  state_e               state_q, state_d;
  logic [PosW-1:0]      pos_q, pos_d, pos_next;
  logic [PosW-1:0]      kept_q, kept_d;
  logic                 started_q, started_d;
  logic [31:0]          crc_q, crc_d;
  logic [31:0]          seq_q, seq_d;
  logic [31:0]          seq_inc;
  logic [1:0]           j_q, j_d;
  logic [55:0]          asm_q, asm_d;
  logic                 out_valid_q, out_valid_d;
  lsf_pkg::slot_item_t  out_q, out_d;

  logic                 place_en, place_feed, seq_place, consume, pop_empty, stall;
  logic [7:0]           place_byte, cur_byte;

  assign slot_o.valid   = out_valid_q;
  assign slot_o.payload = out_q;
  assign seq_o          = seq_q;

  assign cur_byte = 8'(q_i.head.bytes >> {j_q, 3'b000});
  assign seq_inc  = seq_q + 32'd1;

  // Choose this cycle's slot byte
  always_comb begin
    place_en   = 1'b0;
    place_feed = 1'b0;
    place_byte = '0;
    seq_place  = 1'b0;
    consume    = 1'b0;
    pop_empty  = 1'b0;
    case (state_q)
      ST_TEXT: begin
        if (q_i.valid) begin
          if (q_i.head.count == 2'd0) begin
            pop_empty = 1'b1;
          end else if (!started_q) begin
            place_en   = 1'b1;
            place_feed = 1'b1;
            seq_place  = 1'b1;
            place_byte = 8'(seq_q >> {pos_q[1:0], 3'b000});
          end else begin
            consume = 1'b1;
            if (pos_q < CrcPos) begin
              place_en   = 1'b1;
              place_feed = 1'b1;
              place_byte = cur_byte;
            end
          end
        end
      end
      ST_FIN: begin
        place_en = 1'b1;
        if (pos_q < CrcPos) begin
          place_feed = 1'b1;
          place_byte = '0;
        end else begin
          place_byte = 8'(~crc_q >> {pos_q[1:0], 3'b000});
        end
      end
      default: begin
        place_en = 1'b0;
      end
    endcase
  end

  // Hold the slot state while a completed word cannot enter the output register
  assign stall    = place_en && (pos_q[2:0] == 3'b111) && out_valid_q && !slot_o.ready;
  assign pos_next = place_en ? pos_q + 1'b1 : pos_q;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    kept_d      = kept_q;
    started_d   = started_q;
    crc_d       = crc_q;
    seq_d       = seq_q;
    j_d         = j_q;
    asm_d       = asm_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !slot_o.ready;
    pop_o       = 1'b0;
    if (!stall) begin
      if (place_en) begin
        pos_d = pos_next;
        if (place_feed) begin
          crc_d = lsf_pkg::crc_feed(crc_q, place_byte);
        end
        for (int k = 0; k < 7; k++) begin
          if (pos_q[2:0] == 3'(k)) begin
            asm_d[8*k +: 8] = place_byte;
          end
        end
        if (pos_q[2:0] == 3'b111) begin
          out_valid_d         = 1'b1;
          out_d.slot_word     = {place_byte, asm_q};
          out_d.word_index    = 4'(pos_q >> 3);
          out_d.last_word     = (pos_q == SlotLast);
          out_d.record_length = (pos_q == SlotLast) ? 7'(kept_q) : 7'd0;
        end
      end
      if (seq_place && pos_q[1:0] == 2'b11) begin
        started_d = 1'b1;
      end
      // Retire a request once its last byte is handled
      if (consume) begin
        if (j_q == q_i.head.count - 2'd1) begin
          pop_o = 1'b1;
          j_d   = '0;
          if (q_i.head.finish) begin
            state_d = ST_FIN;
            kept_d  = pos_next - PosW'(4);
          end
        end else begin
          j_d = j_q + 2'd1;
        end
      end
      if (pop_empty) begin
        pop_o = 1'b1;
        if (q_i.head.finish && started_q) begin
          state_d = ST_FIN;
          kept_d  = pos_q - PosW'(4);
        end
      end
      // Close the slot: advance the sequence and reset the line
      if (state_q == ST_FIN && pos_q == SlotLast) begin
        seq_d     = (seq_inc == lsf_pkg::SEQ_SKIP) ? 32'd0 : seq_inc;
        pos_d     = '0;
        started_d = 1'b0;
        crc_d     = lsf_pkg::CRC_INIT;
        state_d   = ST_TEXT;
      end
    end
    if (cfg_we_i) begin
      seq_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_TEXT;
      pos_q       <= '0;
      kept_q      <= '0;
      started_q   <= 1'b0;
      crc_q       <= lsf_pkg::CRC_INIT;
      seq_q       <= '0;
      j_q         <= '0;
      asm_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      kept_q      <= kept_d;
      started_q   <= started_d;
      crc_q       <= crc_d;
      seq_q       <= seq_d;
      j_q         <= j_d;
      asm_q       <= asm_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

### rtl/log_slot_framer_crc32_unit.sv
// Log slot framer: turns each non-empty text line into one SLOT_BYTES-byte
// slot (sequence number, zero-padded text, CRC-32) sent as 64-bit words.
// Depends on lsf_pkg, lsf_stream_if, lsf_front, lsf_queue and lsf_back.
//
// Text bytes are accepted one per cycle while the four-entry request queue
// has room. The back end places one slot byte per cycle unless stalled,
// filling all SLOT_BYTES bytes of a slot (sequence, text, padding, CRC);
// a text byte beyond the 120-byte capacity is consumed but not placed.
// That byte loop sets the sustained rate; input can stall once the queue
// fills while padding drains. Words leave through a one-entry output
// register, one per eight slot bytes. A trailing CR LF or lone LF is
// stripped; an empty line sends nothing, its request just popped by the back end.
// Register 0 (byte address 0) loads the sequence number for the next slot;
// 0xFFFFFFFF is skipped when the counter advances. There is no clearing pass.
module log_slot_framer_crc32_unit #(
  parameter int unsigned SLOT_BYTES = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lsf_stream_if.sink   text_i,
  lsf_stream_if.source slot_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  lsf_pkg::q_push_t   push;
  lsf_pkg::q_status_t q_status;
  logic               pop;
  logic               cfg_we;
  logic [31:0]        seq;

  // Decode register reads and writes; only register 0 exists
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? seq : 32'd0;

  lsf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_i),
    .q_full_i (q_status.full),
    .push_o   (push)
  );

  lsf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .status_o (q_status)
  );

  lsf_back #(
    .SLOT_BYTES (SLOT_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_i        (q_status),
    .pop_o      (pop),
    .slot_o     (slot_o),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (pwdata),
    .seq_o      (seq)
  );

endmodule

### rtl/lsf_checker.sv
// Port-level checks for the log slot framer, bound to the top level.
// Depends only on the top level's ports.
module lsf_checker #(
  parameter int unsigned SLOT_BYTES = 128
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] slot_word_i,
  input logic [3:0]  word_index_i,
  input logic        last_word_i,
  input logic [6:0]  record_length_i,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(slot_word_i)
      && $stable(word_index_i) && $stable(last_word_i) && $stable(record_length_i))
    else $error("stalled slot word changed");

  // The CRC word sits at the end of the slot
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_word_i |-> word_index_i == 4'(SLOT_BYTES / 8 - 1))
    else $error("last word at wrong index");

  // Length is reported on the last word only
  a_len_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && record_length_i != 7'd0 |-> last_word_i)
    else $error("record length on a non-final word");

  // A sequence write reads back on the next cycle
  a_cfg_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr == 3'd0 |=> paddr != 3'd0 || prdata == $past(pwdata))
    else $error("sequence register read-back mismatch");

endmodule

bind log_slot_framer_crc32_unit lsf_checker #(
  .SLOT_BYTES (SLOT_BYTES)
) u_lsf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (slot_o.valid),
  .out_ready_i     (slot_o.ready),
  .slot_word_i     (slot_o.payload.slot_word),
  .word_index_i    (slot_o.payload.word_index),
  .last_word_i     (slot_o.payload.last_word),
  .record_length_i (slot_o.payload.record_length),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata)
);
